@@ sv/fslm_pkg.sv @@
// Shared types, constants and helpers for the fixed-string line matcher.
package fslm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_WORDS   = 4;
    localparam int LEN_W       = 6;
    localparam int LINE_W      = 32;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_0  = 3'd0,
        REG_PATTERN_1  = 3'd1,
        REG_PATTERN_2  = 3'd2,
        REG_PATTERN_3  = 3'd3,
        REG_LENGTH     = 3'd4,
        REG_IGNORECASE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [LEN_W-1:0]       length;
        logic                   ignore_case;
    } t_cfg;

    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ sv/fslm_regs.sv @@
// APB register file holding the pattern, its length and the case-fold flag.
module fslm_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fslm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fslm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fslm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output fslm_pkg::t_cfg                     o_cfg
);
    import fslm_pkg::*;

    logic [63:0]      r_word [PAT_WORDS];
    logic [LEN_W-1:0] r_len;
    logic             r_icase;
    logic             wr_en;
    t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_word[w] <= '0;
            end
            r_len   <= '0;
            r_icase <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_PATTERN_0:  r_word[0] <= pwdata;
                REG_PATTERN_1:  r_word[1] <= pwdata;
                REG_PATTERN_2:  r_word[2] <= pwdata;
                REG_PATTERN_3:  r_word[3] <= pwdata;
                REG_LENGTH:     r_len     <= pwdata[LEN_W-1:0];
                REG_IGNORECASE: r_icase   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PATTERN_0:  prdata = r_word[0];
            REG_PATTERN_1:  prdata = r_word[1];
            REG_PATTERN_2:  prdata = r_word[2];
            REG_PATTERN_3:  prdata = r_word[3];
            REG_LENGTH:     prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_len};
            REG_IGNORECASE: prdata = {{(APB_DATA_W-1){1'b0}}, r_icase};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.pattern     = {r_word[3], r_word[2], r_word[1], r_word[0]};
    assign o_cfg.length      = r_len;
    assign o_cfg.ignore_case = r_icase;

endmodule

@@ sv/fslm_match.sv @@
// Shift-and match step and per-line state: partial matches, hit, NUL cut, line count.
module fslm_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fslm_pkg::t_cfg                 i_cfg,
    input  logic                           i_step,
    input  logic [7:0]                     i_byte,
    input  logic                           i_eof,
    output logic                           o_ends,
    output logic [fslm_pkg::LINE_W-1:0]    o_line_number,
    output logic                           o_matched
);
    import fslm_pkg::*;

    logic [MAX_PATTERN-1:0] r_prefix, n_prefix;
    logic                   r_hit, n_hit;
    logic                   r_cut, n_cut;
    logic [LINE_W-1:0]      r_lines, n_lines;

    logic [LEN_W-1:0]       lim;
    logic [LEN_W-1:0]       eff_len;
    logic                   zero_found;
    logic [7:0]             text_f;
    logic [MAX_PATTERN-1:0] mask;
    logic [MAX_PATTERN:0]   keep_wide;
    logic [MAX_PATTERN-1:0] shifted;
    logic [4:0]             top_idx;
    logic                   process;
    logic                   hit_now;
    logic                   hit_cur;

    // effective length: capped length, cut at the first zero pattern byte
    always_comb begin
        lim        = (i_cfg.length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : i_cfg.length;
        eff_len    = lim;
        zero_found = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (!zero_found && LEN_W'(k) < lim && i_cfg.pattern[8*k +: 8] == CHAR_NUL) begin
                eff_len    = LEN_W'(k);
                zero_found = 1'b1;
            end
        end
    end

    always_comb begin
        text_f = fold_case(i_byte, i_cfg.ignore_case);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            mask[k] = fold_case(i_cfg.pattern[8*k +: 8], i_cfg.ignore_case) == text_f;
        end
    end

    assign keep_wide = ((MAX_PATTERN+1)'(1) << eff_len) - (MAX_PATTERN+1)'(1);
    assign shifted   = {r_prefix[MAX_PATTERN-2:0], 1'b1} & mask & keep_wide[MAX_PATTERN-1:0];
    assign top_idx   = eff_len[4:0] - 5'd1;
    assign process   = !r_cut && i_byte != CHAR_NUL && eff_len != '0;
    assign hit_now   = process && shifted[top_idx];
    assign hit_cur   = r_hit || hit_now;

    assign o_ends        = i_byte == CHAR_NEWLINE || i_eof;
    assign o_matched     = eff_len == '0 || hit_cur;
    assign o_line_number = (&r_lines) ? r_lines : r_lines + LINE_W'(1);

    always_comb begin
        n_prefix = r_prefix;
        n_hit    = r_hit;
        n_cut    = r_cut;
        n_lines  = r_lines;
        if (i_step) begin
            if (o_ends) begin
                n_prefix = '0;
                n_hit    = 1'b0;
                n_cut    = 1'b0;
                n_lines  = i_eof ? '0 : o_line_number;
            end else begin
                if (process) begin
                    n_prefix = shifted;
                end
                n_hit = hit_cur;
                n_cut = r_cut || i_byte == CHAR_NUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_hit    <= 1'b0;
            r_cut    <= 1'b0;
            r_lines  <= '0;
        end else begin
            r_prefix <= n_prefix;
            r_hit    <= n_hit;
            r_cut    <= n_cut;
            r_lines  <= n_lines;
        end
    end

endmodule

@@ sv/fixed_string_line_matcher_core.sv @@
// Top level of the fixed-string line matcher: input stage, match step, result stage.
//
// Text enters on the s_ stream one byte per word: s_tdata carries the byte,
// s_tlast flags the last byte of a file. One result word leaves on the m_
// stream for every newline byte and for every byte flagged last: m_tdata is
// the line number within the file (from 1, saturating), m_tuser is set when
// the pattern occurs in that line, m_tlast marks the last line of the file.
// The pattern, its length and the case-fold flag are set over the APB port
// (64-bit registers at byte offsets 0, 8, 16, 24, 32, 40); the user must set
// them only while the stream is idle, and the block itself does not enforce this.
// A byte accepted on s_ is held in the input register, goes through the match
// step and, if it ends a line, its result is registered in the result register
// that drives m_. One byte is taken every cycle unless a line-ending byte waits
// on a held result; the rate is set by the single shift-and update between those registers.
// When the receiver stalls, the result is held and the block keeps taking
// bytes that end no line; a line-ending byte then waits in the input register
// and s_tready drops until the held result is taken.
// Reset clears the line state, the line count, the registers and both stages.
module fixed_string_line_matcher_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] text_byte
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fslm_pkg::LINE_W-1:0]        m_tdata,   // [31:0] line_number
    output logic                               m_tuser,   // [0] matched
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fslm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fslm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fslm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import fslm_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eof;
    logic              r_out_valid;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_match;
    logic              r_out_last;

    logic              ends;
    logic [LINE_W-1:0] line_number;
    logic              matched;
    logic              advance;
    logic              out_free;

    fslm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fslm_match u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_eof         (r_in_eof),
        .o_ends        (ends),
        .o_line_number (line_number),
        .o_matched     (matched)
    );

    assign out_free = !r_out_valid || m_tready;
    // a byte that ends no line never needs the result register
    assign advance  = r_in_valid && (!ends || out_free);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_eof  <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && ends;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ends) begin
            r_out_line  <= line_number;
            r_out_match <= matched;
            r_out_last  <= r_in_eof;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_line;
    assign m_tuser  = r_out_match;
    assign m_tlast  = r_out_last;

endmodule

@@ sv/fslm_checker.sv @@
// Port-level checks for the fixed-string line matcher, bound to the top level.
module fslm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [7:0]                      s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fslm_pkg::LINE_W-1:0]     m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import fslm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata != '0)
        else $error("line number zero on result");

    a_ready_only_blocked_by_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_result_from_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2)
            && ($past(s_tdata, 2) == CHAR_NEWLINE || $past(s_tlast, 2)))
        else $error("result not caused by a line-ending byte two cycles earlier");

endmodule

bind fixed_string_line_matcher_core fslm_checker u_fslm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ bench/testbench.sv @@
// Self-checking bench for the fixed-string line matcher: directed table, then random text.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fslm_pkg::*;

    localparam int          ITEM_TARGET  = 1750;
    localparam int          DIRECTED     = 25;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [31:0] LETTERS      = 32'h4241_6261;   // a b A B
    localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic              matched;
        logic              file_done;
    } t_line_result;

    typedef enum logic {ROW_TEXT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic [7:0]   data;
        logic         eof;
        logic         typed;
        t_line_result want;
        t_reg_idx     reg_sel;
        logic [63:0]  value;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [LINE_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the registers and the line state
    logic [63:0]       cfg_word [PAT_WORDS];
    logic [LEN_W-1:0]  cfg_len;
    logic              cfg_fold;
    logic [31:0]       partial_hits;
    logic              hit_in_line;
    logic              nul_in_line;
    logic [LINE_W-1:0] line_count;

    t_line_result lines_due [$];
    int           mismatches   = 0;
    int           item_count   = 0;
    int           cycle_count  = 0;
    int           tx_max_gap   = 6;
    int           rx_max_gap   = 6;
    bit           hold_results = 1'b0;

    fixed_string_line_matcher_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] pattern_byte(int k);
        return cfg_word[k / 8][8 * (k % 8) +: 8];
    endfunction

    function automatic logic [7:0] lower_if_folding(logic [7:0] c);
        if (cfg_fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Pattern in use ends at the first zero byte
    function automatic int used_length();
        int lim;
        lim = (int'(cfg_len) > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
        for (int k = 0; k < lim; k++) begin
            if (pattern_byte(k) == 8'h00) begin
                return k;
            end
        end
        return lim;
    endfunction

    function automatic bit scan_byte(input logic [7:0] c, input logic eof,
                                     output t_line_result res);
        int          len;
        logic [31:0] mask;
        logic [31:0] keep;
        logic [7:0]  t;
        len = used_length();
        res = '0;
        if (!nul_in_line) begin
            if (c == CHAR_NUL) begin
                nul_in_line = 1'b1;
            end else if (len > 0) begin
                t = lower_if_folding(c);
                mask = '0;
                for (int k = 0; k < len; k++) begin
                    if (lower_if_folding(pattern_byte(k)) == t) begin
                        mask[k] = 1'b1;
                    end
                end
                keep = (len >= 32) ? 32'hFFFF_FFFF : ((32'h1 << len) - 32'h1);
                partial_hits = ((partial_hits << 1) | 32'h1) & mask & keep;
                if (partial_hits[len-1]) begin
                    hit_in_line = 1'b1;
                end
            end
        end
        if (c != CHAR_NEWLINE && !eof) begin
            return 1'b0;
        end
        if (line_count != '1) begin
            line_count = line_count + 1'b1;
        end
        res.line_number = line_count;
        res.matched     = (len == 0) || hit_in_line;
        res.file_done   = eof;
        partial_hits = '0;
        hit_in_line  = 1'b0;
        nul_in_line  = 1'b0;
        if (eof) begin
            line_count = '0;
        end
        return 1'b1;
    endfunction

    function automatic t_script_row text_row(logic [7:0] c);
        t_script_row r;
        r = '{ROW_TEXT, c, 1'b0, 1'b0, '0, REG_PATTERN_0, '0};
        return r;
    endfunction

    function automatic t_script_row line_row(logic [7:0] c, logic eof, int line,
                                             logic m, logic d);
        t_script_row r;
        r = '{ROW_TEXT, c, eof, 1'b1, '{line, m, d}, REG_PATTERN_0, '0};
        return r;
    endfunction

    function automatic t_script_row cfg_row(t_reg_idx idx, logic [63:0] val);
        t_script_row r;
        r = '{ROW_CFG, 8'h00, 1'b0, 1'b0, '0, idx, val};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic eof, input logic typed,
                             input t_line_result want);
        int           gap;
        bit           produced;
        t_line_result res;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eof;
        do @(posedge i_clk); while (!s_tready);
        item_count++;
        produced = scan_byte(c, eof, res);
        if (produced) begin
            lines_due.push_back(typed ? want : res);
        end
    endtask

    // Drain the pipe: wait for every line, then let trailing bytes settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (lines_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_LENGTH:     cfg_len  = val[LEN_W-1:0];
            REG_IGNORECASE: cfg_fold = val[0];
            default:        cfg_word[int'(idx)] = val;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_random_setup();
        logic [63:0] words [PAT_WORDS];
        logic [63:0] len_val;
        logic [63:0] fold_val;
        logic [7:0]  b;
        int          style;
        int          pick;
        int          zpos;
        style = $urandom_range(0, 9);
        for (int k = 0; k < PAT_BYTES; k++) begin
            pick = $urandom_range(0, 3);
            case (style)
                0:       b = 8'($urandom_range(0, 255));
                1:       b = 8'hFF;
                2:       b = 8'h00;
                default: b = ($urandom_range(0, 11) == 0) ? CHAR_NEWLINE
                                                          : LETTERS[8 * pick +: 8];
            endcase
            words[k / 8][8 * (k % 8) +: 8] = b;
        end
        if ($urandom_range(0, 9) == 0) begin
            zpos = $urandom_range(0, PAT_BYTES - 1);
            words[zpos / 8][8 * (zpos % 8) +: 8] = 8'h00;
        end
        // Upper bits are junk; only the low field counts
        len_val  = {$urandom, $urandom};
        fold_val = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       len_val[LEN_W-1:0] = 6'd0;
            1:       len_val[LEN_W-1:0] = 6'd1;
            2:       len_val[LEN_W-1:0] = 6'd32;
            3:       len_val[LEN_W-1:0] = 6'($urandom_range(33, 63));
            default: len_val[LEN_W-1:0] = 6'($urandom_range(2, 8));
        endcase
        write_reg(REG_PATTERN_0, words[0]);
        write_reg(REG_PATTERN_1, words[1]);
        write_reg(REG_PATTERN_2, words[2]);
        write_reg(REG_PATTERN_3, words[3]);
        write_reg(REG_LENGTH, len_val);
        write_reg(REG_IGNORECASE, fold_val);
        apb_release();
    endtask

    // Mix pattern copies, near misses, letters, noise and NUL into one line
    task automatic send_random_line(input bit eof_line, input bit cut_short);
        int         pieces;
        int         len;
        int         m;
        int         pick;
        logic [7:0] c;
        len = used_length();
        pieces = $urandom_range(0, 4);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    m = (len == 0) ? 0 : ($urandom_range(0, 1) ? len : $urandom_range(1, len));
                    for (int k = 0; k < m; k++) begin
                        c = pattern_byte(k);
                        if ($urandom_range(0, 3) == 0 &&
                            ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))) begin
                            c = c ^ CASE_OFFSET;
                        end
                        send_byte(c, 1'b0, 1'b0, '0);
                    end
                end
                4, 5, 6: begin
                    pick = $urandom_range(0, 3);
                    send_byte(LETTERS[8 * pick +: 8], 1'b0, 1'b0, '0);
                end
                7, 8: begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                end
                default: begin
                    send_byte(CHAR_NUL, 1'b0, 1'b0, '0);
                end
            endcase
        end
        if (!cut_short) begin
            if (eof_line && $urandom_range(0, 1)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            end else begin
                send_byte(CHAR_NEWLINE, eof_line, 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        t_script_row script [$];
        bit          in_cfg;
        int          phase;
        int          lines_in_phase;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        for (int w = 0; w < PAT_WORDS; w++) begin
            cfg_word[w] = '0;
        end
        cfg_len      = '0;
        cfg_fold     = 1'b0;
        partial_hits = '0;
        hit_in_line  = 1'b0;
        nul_in_line  = 1'b0;
        line_count   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        script = '{
            // empty pattern after reset: every line matches
            text_row(8'h78),
            line_row(CHAR_NEWLINE, 1'b0, 1, 1'b1, 1'b0),
            line_row(8'hFF, 1'b1, 2, 1'b1, 1'b1),
            // "Ab\n", newline inside the pattern
            cfg_row(REG_PATTERN_0, 64'h0000_0000_000A_6241),
            cfg_row(REG_LENGTH, 64'd3),
            cfg_row(REG_IGNORECASE, 64'd0),
            text_row(8'h78), text_row(8'h41), text_row(8'h62),
            line_row(CHAR_NEWLINE, 1'b0, 1, 1'b1, 1'b0),
            text_row(8'h61), text_row(8'h62),
            line_row(CHAR_NEWLINE, 1'b0, 2, 1'b0, 1'b0),
            // case folding, newline flagged as file end
            cfg_row(REG_IGNORECASE, 64'd1),
            text_row(8'h61), text_row(8'h42),
            line_row(CHAR_NEWLINE, 1'b1, 3, 1'b1, 1'b1),
            // NUL cuts the rest of the line
            text_row(8'h41), text_row(CHAR_NUL), text_row(8'h62),
            line_row(CHAR_NEWLINE, 1'b0, 1, 1'b0, 1'b0),
            // zero byte inside the pattern shortens it
            cfg_row(REG_PATTERN_0, 64'h0000_0000_0062_0061),
            text_row(8'h61),
            line_row(CHAR_NEWLINE, 1'b0, 2, 1'b1, 1'b0),
            // longest pattern, then an oversized length
            cfg_row(REG_PATTERN_0, 64'h7A7A_7A7A_7A7A_7A7A),
            cfg_row(REG_PATTERN_1, 64'h7A7A_7A7A_7A7A_7A7A),
            cfg_row(REG_PATTERN_2, 64'h7A7A_7A7A_7A7A_7A7A),
            cfg_row(REG_PATTERN_3, 64'h7A7A_7A7A_7A7A_7A7A),
            cfg_row(REG_LENGTH, 64'd32),
            text_row(8'h7A),
            line_row(CHAR_NEWLINE, 1'b0, 3, 1'b0, 1'b0),
            cfg_row(REG_LENGTH, 64'd63),
            line_row(8'h5A, 1'b1, 4, 1'b0, 1'b1),
            // pattern swapped mid-line keeps the partial match
            cfg_row(REG_PATTERN_0, 64'h0000_0000_0000_6261),
            cfg_row(REG_LENGTH, 64'd2),
            cfg_row(REG_IGNORECASE, 64'd0),
            text_row(8'h61),
            cfg_row(REG_PATTERN_0, 64'h0000_0000_0000_6263),
            text_row(8'h62),
            line_row(CHAR_NEWLINE, 1'b0, 1, 1'b1, 1'b0)
        };

        in_cfg = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(script[i].reg_sel, script[i].value);
            end else begin
                if (in_cfg) begin
                    apb_release();
                    in_cfg = 1'b0;
                end
                send_byte(script[i].data, script[i].eof, script[i].typed, script[i].want);
            end
        end

        phase = 0;
        while (item_count < DIRECTED + ITEM_TARGET) begin
            wait_idle();
            load_random_setup();
            phase++;
            tx_max_gap = (phase % 6 == 2) ? 0 : 6;
            rx_max_gap = tx_max_gap;
            if (phase == 3) begin
                // results back up while text keeps coming
                tx_max_gap   = 0;
                hold_results = 1'b1;
            end
            lines_in_phase = $urandom_range(8, 20);
            repeat (lines_in_phase) begin
                send_random_line($urandom_range(0, 7) == 0, 1'b0);
            end
            // sometimes leave the line open across the next register change
            send_random_line(1'b0, $urandom_range(0, 2) == 0);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_side
        int gap;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_line_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (lines_due.size() == 0) begin
                report_mismatch("result with no line pending, line_number", m_tdata, 0);
            end else begin
                want = lines_due.pop_front();
                if (m_tdata !== want.line_number) begin
                    report_mismatch("line_number", m_tdata, want.line_number);
                end
                if (m_tuser !== want.matched) begin
                    report_mismatch("matched", 32'(m_tuser), 32'(want.matched));
                end
                if (m_tlast !== want.file_done) begin
                    report_mismatch("file_done", 32'(m_tlast), 32'(want.file_done));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
sv/fslm_pkg.sv
sv/fslm_regs.sv
sv/fslm_match.sv
sv/fixed_string_line_matcher_core.sv
sv/fslm_checker.sv
bench/testbench.sv
